>>> design/lph_pkg.sv
// shared types and codes for the linear probe hash table
package lph_pkg;

    localparam int KEY_W   = 32;
    localparam int INDEX_W = 4;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam logic [1:0] STATUS_INSERTED  = 2'd0;
    localparam logic [1:0] STATUS_FOUND     = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STATUS_FULL      = 2'd3;

    typedef struct packed {
        logic              command;
        logic [KEY_W-1:0]  key;
    } t_in_word;

    typedef struct packed {
        logic [1:0]          status;
        logic [INDEX_W-1:0]  slot_index;
    } t_out_word;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
    } t_slot;

endpackage

>>> design/lph_mod.sv
// remainder unit: key modulo the slot count by reciprocal multiplication
module lph_mod #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [lph_pkg::KEY_W-1:0]           i_key,
    output logic                                o_done,
    output logic [$clog2(SLOT_COUNT)-1:0]       o_rem
);
    import lph_pkg::*;

    localparam int IW    = $clog2(SLOT_COUNT);
    localparam int SHIFT = KEY_W + IW;
    localparam int PW    = 2 * KEY_W + 1;
    localparam int QW    = PW - SHIFT;

    // ceil(2^SHIFT / SLOT_COUNT) fits in KEY_W + 1 bits and gives the exact quotient
    localparam logic [63:0]      RECIP_WIDE =
        ((64'd1 << SHIFT) + 64'(SLOT_COUNT) - 64'd1) / 64'(SLOT_COUNT);
    localparam logic [KEY_W:0]   RECIP      = RECIP_WIDE[KEY_W:0];
    localparam logic [KEY_W-1:0] DIVISOR    = KEY_W'(SLOT_COUNT);

    logic [KEY_W-1:0] r_key;
    logic [QW-1:0]    r_quot;
    logic [IW-1:0]    r_rem;
    logic             r_mul;
    logic             r_sub;
    logic             r_done;
    logic [PW-1:0]    w_prod;
    logic [KEY_W-1:0] w_back;
    logic [KEY_W-1:0] w_diff;

    // quotient from the reciprocal, then multiply back and subtract
    assign w_prod = PW'(r_key) * PW'(RECIP);
    assign w_back = KEY_W'(r_quot) * DIVISOR;
    assign w_diff = r_key - w_back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul  <= 1'b0;
            r_sub  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_mul  <= i_start;
            r_sub  <= r_mul;
            r_done <= r_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= i_key;
        end
        if (r_mul) begin
            r_quot <= w_prod[PW-1:SHIFT];
        end
        if (r_sub) begin
            r_rem <= w_diff[IW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> design/lph_store.sv
// slot memory: valid flag and key per slot, one write and one registered read
module lph_store #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [$clog2(SLOT_COUNT)-1:0]   i_waddr,
    input  lph_pkg::t_slot                  i_wdata,
    input  logic [$clog2(SLOT_COUNT)-1:0]   i_raddr,
    output lph_pkg::t_slot                  o_rdata
);
    import lph_pkg::*;

    t_slot r_mem [SLOT_COUNT];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/linear_probe_hash_table_unit.sv
// top level of the linear probe hash table: sequencer, remainder unit, slot memory
//
// Open-addressing hash table, SLOT_COUNT slots, linear probing from slot
// key % SLOT_COUNT. After reset the block clears every slot of the slot
// memory with busy high. A word is taken when start is high and busy is
// low; busy then stays high until the result. An item goes through the
// remainder unit (reciprocal multiply, then multiply back and subtract), a
// state that addresses the home slot, then visits slots one memory read
// per cycle, 1 to SLOT_COUNT slots. The result appears on o_result with
// o_done high for exactly one cycle, the cycle in which busy falls. The
// receiver cannot stall: the result must be taken in that cycle.
// Insert into a full table reports table full; slot_index carries the low 4
// bits of the slot.
module linear_probe_hash_table_unit #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  lph_pkg::t_in_word   i_item,
    output logic                busy,
    output logic                o_done,
    output lph_pkg::t_out_word  o_result
);
    import lph_pkg::*;

    localparam int IW = $clog2(SLOT_COUNT);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_HOME,
        ST_PROBE
    } t_state;

    t_state           r_state;
    logic [IW-1:0]    r_slot;
    logic [IW-1:0]    r_count;
    logic             r_cmd;
    logic [KEY_W-1:0] r_key;
    logic             r_done;
    t_out_word        r_result;

    logic             w_mod_start;
    logic             w_mod_done;
    logic [IW-1:0]    w_mod_rem;
    logic             w_we;
    logic [IW-1:0]    w_waddr;
    t_slot            w_wdata;
    logic [IW-1:0]    w_raddr;
    t_slot            w_rdata;
    logic [IW-1:0]    w_next;
    logic             w_last;
    logic [IW+3:0]    w_idx_wide;

    assign w_mod_start = (r_state == ST_IDLE) && start;
    assign w_next      = (r_slot == IW'(SLOT_COUNT - 1)) ? '0 : r_slot + 1'b1;
    assign w_last      = (r_count == IW'(SLOT_COUNT - 1));
    assign w_idx_wide  = {4'b0, r_slot};

    lph_mod #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_key   (i_item.key),
        .o_done  (w_mod_done),
        .o_rem   (w_mod_rem)
    );

    lph_store #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // memory write: clearing pass, or storing a key on insert
    always_comb begin
        w_we          = 1'b0;
        w_waddr       = r_slot;
        w_wdata.valid = 1'b0;
        w_wdata.key   = r_key;
        if (r_state == ST_CLEAR) begin
            w_we = 1'b1;
        end else if (r_state == ST_PROBE && r_cmd == CMD_INSERT && !w_rdata.valid) begin
            w_we          = 1'b1;
            w_wdata.valid = 1'b1;
        end
    end

    // read address runs one slot ahead so the data lines up with r_slot
    always_comb begin
        w_raddr = r_slot;
        if (r_state == ST_PROBE) begin
            w_raddr = w_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_slot   <= '0;
            r_count  <= '0;
            r_done   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_CLEAR: begin
                    r_slot <= w_next;
                    if (r_slot == IW'(SLOT_COUNT - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (start) begin
                        r_cmd   <= i_item.command;
                        r_key   <= i_item.key;
                        r_state <= ST_MOD;
                    end
                end
                ST_MOD: begin
                    if (w_mod_done) begin
                        r_slot  <= w_mod_rem;
                        r_state <= ST_HOME;
                    end
                end
                ST_HOME: begin
                    r_count <= '0;
                    r_state <= ST_PROBE;
                end
                ST_PROBE: begin
                    if (r_cmd == CMD_INSERT) begin
                        if (!w_rdata.valid) begin
                            r_result.status     <= STATUS_INSERTED;
                            r_result.slot_index <= w_idx_wide[3:0];
                            r_done              <= 1'b1;
                            r_state             <= ST_IDLE;
                        end else if (w_last) begin
                            r_result.status     <= STATUS_FULL;
                            r_result.slot_index <= '0;
                            r_done              <= 1'b1;
                            r_state             <= ST_IDLE;
                        end else begin
                            r_slot  <= w_next;
                            r_count <= r_count + 1'b1;
                        end
                    end else begin
                        if (w_rdata.valid && w_rdata.key == r_key) begin
                            r_result.status     <= STATUS_FOUND;
                            r_result.slot_index <= w_idx_wide[3:0];
                            r_done              <= 1'b1;
                            r_state             <= ST_IDLE;
                        end else if (!w_rdata.valid || w_last) begin
                            r_result.status     <= STATUS_NOT_FOUND;
                            r_result.slot_index <= '0;
                            r_done              <= 1'b1;
                            r_state             <= ST_IDLE;
                        end else begin
                            r_slot  <= w_next;
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

>>> tb/linear_probe_hash_table_unit_test.sv
// self-checking testbench for the linear probe hash table unit
`timescale 1ns / 1ps

module linear_probe_hash_table_unit_test;
    import lph_pkg::*;

    localparam int SLOT_COUNT = 16;

    // tracks table contents and the status words still owed by the block
    class hash_table_scoreboard;
        bit                 slot_used[SLOT_COUNT];
        logic [KEY_W-1:0]   slot_keys[SLOT_COUNT];
        t_out_word          pending_results[$];
        int                 error_count;

        function new();
            foreach (slot_used[i]) begin
                slot_used[i] = 1'b0;
                slot_keys[i] = '0;
            end
            error_count = 0;
        endfunction

        function void note_word(t_in_word w);
            int unsigned slot;
            t_out_word   exp_word;
            bit          done;
            slot = w.key % SLOT_COUNT;
            done = 1'b0;
            for (int n = 0; n < SLOT_COUNT && !done; n++) begin
                if (w.command == CMD_INSERT) begin
                    if (!slot_used[slot]) begin
                        slot_used[slot] = 1'b1;
                        slot_keys[slot] = w.key;
                        done = 1'b1;
                    end
                end else begin
                    // an empty slot ends the walk
                    if (!slot_used[slot]) begin
                        n = SLOT_COUNT;
                    end else if (slot_keys[slot] == w.key) begin
                        done = 1'b1;
                    end
                end
                if (!done) begin
                    slot = (slot + 1) % SLOT_COUNT;
                end
            end
            if (done) begin
                exp_word.status     = (w.command == CMD_INSERT) ? STATUS_INSERTED : STATUS_FOUND;
                exp_word.slot_index = slot[INDEX_W-1:0];
            end else begin
                exp_word.status     = (w.command == CMD_INSERT) ? STATUS_FULL : STATUS_NOT_FOUND;
                exp_word.slot_index = '0;
            end
            pending_results.push_back(exp_word);
        endfunction

        function void check_result(t_out_word r);
            t_out_word exp_word;
            if (pending_results.size() == 0) begin
                $error("unexpected result word: status %0d slot_index %0d",
                       r.status, r.slot_index);
                error_count++;
            end else begin
                exp_word = pending_results.pop_front();
                if (r.status !== exp_word.status) begin
                    $error("status: expected %0d, actual %0d", exp_word.status, r.status);
                    error_count++;
                end
                if (r.slot_index !== exp_word.slot_index) begin
                    $error("slot_index: expected %0d, actual %0d",
                           exp_word.slot_index, r.slot_index);
                    error_count++;
                end
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    t_in_word   i_item;
    logic       busy;
    logic       o_done;
    t_out_word  o_result;

    hash_table_scoreboard sb;
    logic [KEY_W-1:0] stored_keys[$];

    linear_probe_hash_table_unit #(
        .SLOT_COUNT(SLOT_COUNT)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_done  (o_done),
        .o_result(o_result)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            sb.check_result(o_result);
        end
    end

    // present one word, with an optional random hold-off, and wait until it is taken
    task automatic send_word(input logic cmd, input logic [KEY_W-1:0] key_value,
                             input bit may_idle);
        t_in_word    w;
        int unsigned idle_cycles;
        bit          taken;
        w.command = cmd;
        w.key     = key_value;
        idle_cycles = 0;
        if (may_idle && $urandom_range(99) < 38) begin
            idle_cycles = $urandom_range(1, 60);
        end
        @(negedge i_clk);
        repeat (idle_cycles) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= w;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            if (!busy) begin
                taken = 1'b1;
            end
        end
        sb.note_word(w);
        if (cmd == CMD_INSERT) begin
            stored_keys.push_back(key_value);
        end
    endtask

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int               pick;
        int               drain_cycles;
        logic             cmd;
        logic [KEY_W-1:0] key_value;
        bit               may_idle;

        sb = new();
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, extreme keys, collisions, wrap past the last slot, duplicates
        send_word(CMD_SEARCH, 32'h0000_0000, 1'b1);
        send_word(CMD_INSERT, 32'h0000_0000, 1'b1);
        send_word(CMD_INSERT, 32'hFFFF_FFFF, 1'b1);
        send_word(CMD_INSERT, 32'h0000_001F, 1'b1);
        send_word(CMD_INSERT, 32'h0000_0010, 1'b1);
        send_word(CMD_INSERT, 32'h0000_0000, 1'b1);
        send_word(CMD_SEARCH, 32'h0000_0000, 1'b1);
        send_word(CMD_SEARCH, 32'h0000_001F, 1'b1);
        send_word(CMD_SEARCH, 32'h0000_0010, 1'b1);
        send_word(CMD_SEARCH, 32'h0000_0020, 1'b1);
        send_word(CMD_SEARCH, 32'hFFFF_FFFF, 1'b1);
        send_word(CMD_INSERT, 32'h8000_0007, 1'b1);
        send_word(CMD_SEARCH, 32'h0000_0007, 1'b1);
        // fill the remaining ten slots
        repeat (10) send_word(CMD_INSERT, $urandom, 1'b1);
        // full table: insert is refused, a miss walks the whole table
        send_word(CMD_INSERT, 32'h5A5A_A5A5, 1'b1);
        send_word(CMD_SEARCH, 32'h7FFF_FFFE, 1'b1);

        for (int n = 0; n < 900; n++) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                cmd = CMD_SEARCH;
                key_value = stored_keys[$urandom_range(stored_keys.size() - 1)];
            end else if (pick < 70) begin
                // near miss of a stored key
                cmd = CMD_SEARCH;
                key_value = stored_keys[$urandom_range(stored_keys.size() - 1)]
                            ^ (32'h1 << $urandom_range(31));
            end else begin
                cmd = (pick < 85) ? CMD_SEARCH : CMD_INSERT;
                key_value = $urandom_range(1) ? $urandom : $urandom_range(0, 63);
            end
            may_idle = !(n >= 400 && n < 550);
            send_word(cmd, key_value, may_idle);
        end
        @(negedge i_clk);
        start <= 1'b0;

        drain_cycles = 0;
        while (sb.pending_results.size() != 0 && drain_cycles < 4000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (64) @(posedge i_clk);
        if (sb.pending_results.size() != 0) begin
            $error("result words missing: %0d", sb.pending_results.size());
            sb.error_count++;
        end

        if (sb.error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
design/lph_pkg.sv
design/lph_mod.sv
design/lph_store.sv
design/linear_probe_hash_table_unit.sv
tb/linear_probe_hash_table_unit_test.sv
